### src/bbx_pkg.sv
// ----------------------------------------------------------------------------
// bbx_pkg: shared types and constants of the bitmap bounding box
// payload structs, queue entry, control groups and register indexes
// ----------------------------------------------------------------------------
package bbx_pkg;

	localparam int COL_W  = 12;   // column / row coordinate width
	localparam int IW_W   = 13;   // image width register width
	localparam int RW_W   = 8;    // row words register width
	localparam int WPOS_W = 7;    // word position within a row
	localparam int BIT_W  = 5;    // bit index within a 32-bit word

	localparam logic [RW_W-1:0] ROW_WORDS_RESET   = 8'd1;
	localparam logic [RW_W-1:0] ROW_WORDS_MAX     = 8'd128;
	localparam logic [IW_W-1:0] IMAGE_WIDTH_RESET = 13'd32;

	// register indexes, selected by paddr[2]
	localparam logic REG_ROW_WORDS   = 1'b0;
	localparam logic REG_IMAGE_WIDTH = 1'b1;

	typedef struct packed {
		logic [31:0] pixel_word;
		logic        last_word;
	} in_item_t;

	typedef struct packed {
		logic             found;
		logic [COL_W-1:0] rect_left;
		logic [COL_W-1:0] rect_top;
		logic [COL_W-1:0] rect_width;
		logic [COL_W-1:0] rect_height;
		logic [COL_W-1:0] first_col;
		logic [COL_W-1:0] first_row;
		logic [COL_W-1:0] last_col;
		logic [COL_W-1:0] last_row;
	} out_item_t;

	// classified word as handed from front to back
	typedef struct packed {
		logic             nz;
		logic             last;
		logic [COL_W-1:0] lo_col;
		logic [COL_W-1:0] hi_col;
		logic [COL_W-1:0] row;
	} q_item_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

	typedef struct packed {
		logic [IW_W-1:0] image_width;   // current register value
		logic            wr_en;         // image width written this cycle
		logic [IW_W-1:0] wr_value;
	} width_cfg_t;

endpackage

### src/bitmap_bounding_box_top.sv
// ----------------------------------------------------------------------------
// bitmap_bounding_box_top: bounding box of a packed one-bit image
// streams raster words in, reports box and first/last set pixels per image
// ----------------------------------------------------------------------------
// usage
//   in channel: one 32-bit word of pixels per transfer in raster order,
//   bit k is column word*32+k; last_word marks the final word of an image
//   out channel: one result per image, sent after the word flagged last
//   apb port: row_words at 0x0, image_width at 0x4, write only while idle
// throughput
//   one word per clock while no last word waits on a stalled result; the back
//   end folds one word per cycle through a single compare-and-update step on the box registers
// result path
//   the transfer writes the last word into the queue; its pop moves it
//   through the back end into the result register, and a stalled result
//   or older queued words can hold that pop
// reset
//   row_words returns to 1, image_width to 32, all image state but the box registers is cleared
// stall
//   a stalled result holds; the front keeps taking words into the two-entry
//   queue and the back keeps folding words that do not end an image, so the
//   input is stalled only once the queue fills behind a waiting last word
// ----------------------------------------------------------------------------
module bitmap_bounding_box_top #(
	parameter int MAX_ROWS = 4096
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  bbx_pkg::in_item_t  in_data,
	output logic               out_valid,
	input  logic               out_stall,
	output bbx_pkg::out_item_t out_data,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [2:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);

	logic [bbx_pkg::RW_W-1:0] row_words_q;
	logic [bbx_pkg::IW_W-1:0] image_width_q;
	logic                     cfg_wr;
	bbx_pkg::width_cfg_t      width_cfg;
	bbx_pkg::q_status_t       q_status;
	bbx_pkg::q_item_t         push_data;
	bbx_pkg::q_item_t         q_head;
	logic                     push;
	logic                     pop;

	// register file, writes complete on the access phase
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_words_q   <= bbx_pkg::ROW_WORDS_RESET;
			image_width_q <= bbx_pkg::IMAGE_WIDTH_RESET;
		end else if (cfg_wr) begin
			case (paddr[2])
				bbx_pkg::REG_ROW_WORDS:   row_words_q   <= pwdata[bbx_pkg::RW_W-1:0];
				bbx_pkg::REG_IMAGE_WIDTH: image_width_q <= pwdata[bbx_pkg::IW_W-1:0];
				default:                  row_words_q   <= row_words_q;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			bbx_pkg::REG_ROW_WORDS:   prdata = {24'd0, row_words_q};
			bbx_pkg::REG_IMAGE_WIDTH: prdata = {19'd0, image_width_q};
			default:                  prdata = '0;
		endcase
	end

	// a width write also reloads the left minimum while nothing is seen and no word is folded
	always_comb begin
		width_cfg.image_width = image_width_q;
		width_cfg.wr_en       = cfg_wr && (paddr[2] == bbx_pkg::REG_IMAGE_WIDTH);
		width_cfg.wr_value    = pwdata[bbx_pkg::IW_W-1:0];
	end

	// front: position counting and priority encode
	bbx_front #(
		.MAX_ROWS (MAX_ROWS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.row_words (row_words_q),
		.q_status  (q_status),
		.push      (push),
		.push_data (push_data)
	);

	// decoupling queue
	bbx_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.head      (q_head),
		.status    (q_status)
	);

	// back: box accumulation and result register
	bbx_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (q_head),
		.q_status  (q_status),
		.pop       (pop),
		.width_cfg (width_cfg),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

	// a word ending an image always produces a result next cycle
	a_last_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		pop && q_head.last |=> out_valid)
		else $error("no result after last word");

	// a waiting result is never overwritten by the next image
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall && !q_status.empty && q_head.last |-> !pop)
		else $error("result overwritten while stalled");

	// an empty image reports left, width, first column and last row as zero
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.found |-> out_data.rect_left == '0 &&
		out_data.rect_width == '0 && out_data.first_col == '0 &&
		out_data.last_row == '0)
		else $error("empty image with nonzero coordinates");

	// the front never pushes into a full queue
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_status.full |-> !push)
		else $error("push into full queue");

endmodule

### src/bbx_front.sv
// ----------------------------------------------------------------------------
// bbx_front: word acceptor and classifier
// counts word and row position, priority-encodes each word into columns
// ----------------------------------------------------------------------------
module bbx_front #(
	parameter int MAX_ROWS = 4096
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  bbx_pkg::in_item_t        in_data,
	input  logic [bbx_pkg::RW_W-1:0] row_words,
	input  bbx_pkg::q_status_t       q_status,
	output logic                     push,
	output bbx_pkg::q_item_t         push_data
);

	localparam int ROW_CW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam logic [ROW_CW-1:0] ROW_LAST = ROW_CW'(MAX_ROWS - 1);

	logic [bbx_pkg::WPOS_W-1:0] wpos_q;
	logic [ROW_CW-1:0]          row_q;
	logic [bbx_pkg::WPOS_W-1:0] wpos_inc;
	logic [bbx_pkg::RW_W-1:0]   rw_eff;
	logic                       row_end;
	logic [bbx_pkg::BIT_W-1:0]  lo_bit;
	logic [bbx_pkg::BIT_W-1:0]  hi_bit;

	assign in_stall = q_status.full;
	assign push     = in_valid && !q_status.full;

	// zero acts as one, anything above the maximum is clamped
	always_comb begin
		if (row_words == '0) begin
			rw_eff = bbx_pkg::RW_W'(1);
		end else if (row_words > bbx_pkg::ROW_WORDS_MAX) begin
			rw_eff = bbx_pkg::ROW_WORDS_MAX;
		end else begin
			rw_eff = row_words;
		end
	end

	assign wpos_inc = wpos_q + 1'b1;
	assign row_end  = (wpos_inc == '0) || ({1'b0, wpos_inc} >= rw_eff);

	// lowest and highest set bit, 31 and 0 for an empty word
	always_comb begin
		lo_bit = 5'd31;
		hi_bit = 5'd0;
		for (int i = 31; i >= 0; i--) begin
			if (in_data.pixel_word[i]) begin
				lo_bit = 5'(i);
			end
		end
		for (int i = 0; i < 32; i++) begin
			if (in_data.pixel_word[i]) begin
				hi_bit = 5'(i);
			end
		end
	end

	always_comb begin
		push_data.nz     = (in_data.pixel_word != '0);
		push_data.last   = in_data.last_word;
		push_data.lo_col = {wpos_q, lo_bit};
		push_data.hi_col = {wpos_q, hi_bit};
		push_data.row    = bbx_pkg::COL_W'(row_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wpos_q <= '0;
			row_q  <= '0;
		end else if (push) begin
			if (in_data.last_word) begin
				wpos_q <= '0;
				row_q  <= '0;
			end else if (row_end) begin
				wpos_q <= '0;
				row_q  <= (row_q == ROW_LAST) ? '0 : row_q + 1'b1;
			end else begin
				wpos_q <= wpos_inc;
			end
		end
	end

endmodule

### src/bbx_queue.sv
// ----------------------------------------------------------------------------
// bbx_queue: two-entry queue between front and back
// ----------------------------------------------------------------------------
module bbx_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  bbx_pkg::q_item_t   push_data,
	input  logic               pop,
	output bbx_pkg::q_item_t   head,
	output bbx_pkg::q_status_t status
);

	bbx_pkg::q_item_t entry_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	assign head         = entry_q[rd_ptr_q];
	assign status.full  = (count_q == 2'd2);
	assign status.empty = (count_q == 2'd0);

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

### src/bbx_back.sv
// ----------------------------------------------------------------------------
// bbx_back: box accumulator and result register
// folds classified words into the box and emits one result per image
// ----------------------------------------------------------------------------
module bbx_back (
	input  logic                clk,
	input  logic                arst_n,
	input  bbx_pkg::q_item_t    head,
	input  bbx_pkg::q_status_t  q_status,
	output logic                pop,
	input  bbx_pkg::width_cfg_t width_cfg,
	output logic                out_valid,
	input  logic                out_stall,
	output bbx_pkg::out_item_t  out_data
);

	logic                        seen_q, seen_n;
	logic [bbx_pkg::IW_W-1:0]    min_col_q, min_col_n;
	logic [bbx_pkg::COL_W-1:0]   max_col_q, max_col_n;
	logic [bbx_pkg::COL_W-1:0]   min_row_q, min_row_n;
	logic [bbx_pkg::COL_W-1:0]   max_row_q, max_row_n;
	logic [bbx_pkg::COL_W-1:0]   first_col_q, first_col_n;
	logic [bbx_pkg::COL_W-1:0]   first_row_q, first_row_n;
	logic [bbx_pkg::COL_W-1:0]   last_col_q, last_col_n;
	logic [bbx_pkg::COL_W-1:0]   last_row_q, last_row_n;
	logic                        out_valid_q;
	bbx_pkg::out_item_t          out_data_q;
	bbx_pkg::out_item_t          result;

	// a word that ends an image needs the result register free
	assign pop = !q_status.empty && (!head.last || !out_valid_q || !out_stall);

	always_comb begin
		seen_n      = seen_q;
		min_col_n   = min_col_q;
		max_col_n   = max_col_q;
		min_row_n   = min_row_q;
		max_row_n   = max_row_q;
		first_col_n = first_col_q;
		first_row_n = first_row_q;
		last_col_n  = last_col_q;
		last_row_n  = last_row_q;
		if (head.nz) begin
			if (!seen_q) begin
				seen_n      = 1'b1;
				min_row_n   = head.row;
				max_row_n   = head.row;
				max_col_n   = head.hi_col;
				first_col_n = head.lo_col;
				first_row_n = head.row;
			end else begin
				if (head.row < min_row_q) begin
					min_row_n = head.row;
				end
				if (head.row > max_row_q) begin
					max_row_n = head.row;
				end
				if (head.hi_col > max_col_q) begin
					max_col_n = head.hi_col;
				end
			end
			if ({1'b0, head.lo_col} < min_col_q) begin
				min_col_n = {1'b0, head.lo_col};
			end
			last_col_n = head.hi_col;
			last_row_n = head.row;
		end
	end

	always_comb begin
		if (seen_n) begin
			result.found       = 1'b1;
			result.rect_left   = min_col_n[bbx_pkg::COL_W-1:0];
			result.rect_top    = min_row_n;
			result.rect_width  = max_col_n - min_col_n[bbx_pkg::COL_W-1:0];
			result.rect_height = max_row_n - min_row_n;
			result.first_col   = first_col_n;
			result.first_row   = first_row_n;
			result.last_col    = last_col_n;
			result.last_row    = last_row_n;
		end else begin
			result = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q    <= 1'b0;
			min_col_q <= bbx_pkg::IMAGE_WIDTH_RESET;
		end else if (pop) begin
			if (head.last) begin
				seen_q    <= 1'b0;
				min_col_q <= width_cfg.image_width;
			end else begin
				seen_q    <= seen_n;
				min_col_q <= min_col_n;
			end
		end else if (width_cfg.wr_en && !seen_q) begin
			min_col_q <= width_cfg.wr_value;
		end
	end

	// only meaningful once a set pixel is seen
	always_ff @(posedge clk) begin
		if (pop) begin
			max_col_q   <= max_col_n;
			min_row_q   <= min_row_n;
			max_row_q   <= max_row_n;
			first_col_q <= first_col_n;
			first_row_q <= first_row_n;
			last_col_q  <= last_col_n;
			last_row_q  <= last_row_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop && head.last) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop && head.last) begin
			out_data_q <= result;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

### tb/bbx_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbx_checker: scoreboard for the bitmap bounding box
// follows word transfers and register writes, predicts each image's box
// and compares every result transfer field by field
// ----------------------------------------------------------------------------
module bbx_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_stall,
	input  bbx_pkg::in_item_t  in_data,
	input  logic               out_valid,
	input  logic               out_stall,
	input  bbx_pkg::out_item_t out_data,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [2:0]         paddr,
	input  logic [31:0]        pwdata,
	input  logic               pready,
	output int                 pending,
	output int                 fail_count,
	output int                 results_checked
);

	// register copies
	logic [bbx_pkg::RW_W-1:0]     row_words_q;
	logic [bbx_pkg::IW_W-1:0]     width_q;

	// image state
	logic [bbx_pkg::WPOS_W-1:0]   word_pos;
	logic [bbx_pkg::COL_W-1:0]    row_pos;
	logic [bbx_pkg::IW_W-1:0]     min_col;
	logic [bbx_pkg::IW_W-1:0]     max_col;
	logic [bbx_pkg::COL_W-1:0]    min_r;
	logic [bbx_pkg::COL_W-1:0]    max_r;
	logic                         seen;
	logic [2*bbx_pkg::COL_W-1:0]  first_pos;
	logic [2*bbx_pkg::COL_W-1:0]  last_pos;

	bbx_pkg::out_item_t expected_boxes [$];
	int errors = 0;
	int checked = 0;

	string field_names [9] = '{"found", "rect_left", "rect_top", "rect_width",
		"rect_height", "first_col", "first_row", "last_col", "last_row"};

	function automatic logic [bbx_pkg::BIT_W-1:0] low_set(logic [31:0] w);
		for (int b = 0; b < 32; b++)
			if (w[b])
				return bbx_pkg::BIT_W'(b);
		return '1;
	endfunction

	function automatic logic [bbx_pkg::BIT_W-1:0] high_set(logic [31:0] w);
		for (int b = 31; b >= 0; b--)
			if (w[b])
				return bbx_pkg::BIT_W'(b);
		return '0;
	endfunction

	function automatic int unsigned field_of(bbx_pkg::out_item_t r, int i);
		case (i)
			0: return 32'(r.found);
			1: return 32'(r.rect_left);
			2: return 32'(r.rect_top);
			3: return 32'(r.rect_width);
			4: return 32'(r.rect_height);
			5: return 32'(r.first_col);
			6: return 32'(r.first_row);
			7: return 32'(r.last_col);
			default: return 32'(r.last_row);
		endcase
	endfunction

	task automatic clear_image();
		word_pos  = '0;
		row_pos   = '0;
		min_col   = width_q;
		max_col   = '1;
		min_r     = '0;
		max_r     = '0;
		seen      = 1'b0;
		first_pos = '0;
		last_pos  = '0;
	endtask

	task automatic write_reg(logic sel, logic [31:0] value);
		if (sel == bbx_pkg::REG_ROW_WORDS) begin
			row_words_q = value[bbx_pkg::RW_W-1:0];
		end else begin
			width_q = value[bbx_pkg::IW_W-1:0];
			if (!seen)
				min_col = width_q;
		end
	endtask

	task automatic close_image();
		bbx_pkg::out_item_t box;
		logic [bbx_pkg::IW_W-1:0] span;
		box = '0;
		if (seen) begin
			span            = max_col - min_col;
			box.found       = 1'b1;
			box.rect_left   = min_col[bbx_pkg::COL_W-1:0];
			box.rect_top    = min_r;
			box.rect_width  = span[bbx_pkg::COL_W-1:0];
			box.rect_height = max_r - min_r;
			box.first_col   = first_pos[bbx_pkg::COL_W-1:0];
			box.first_row   = first_pos[2*bbx_pkg::COL_W-1:bbx_pkg::COL_W];
			box.last_col    = last_pos[bbx_pkg::COL_W-1:0];
			box.last_row    = last_pos[2*bbx_pkg::COL_W-1:bbx_pkg::COL_W];
		end
		expected_boxes.push_back(box);
		clear_image();
	endtask

	task automatic fold_word(bbx_pkg::in_item_t item);
		logic [bbx_pkg::COL_W-1:0] base;
		logic [bbx_pkg::COL_W-1:0] lo;
		logic [bbx_pkg::COL_W-1:0] hi;
		int eff;
		base = {word_pos, {bbx_pkg::BIT_W{1'b0}}};
		if (item.pixel_word != '0) begin
			lo = base + bbx_pkg::COL_W'(low_set(item.pixel_word));
			hi = base + bbx_pkg::COL_W'(high_set(item.pixel_word));
			if (!seen) begin
				seen      = 1'b1;
				min_r     = row_pos;
				max_r     = row_pos;
				max_col   = {1'b0, hi};
				first_pos = {row_pos, lo};
			end else begin
				if (row_pos < min_r)
					min_r = row_pos;
				if (row_pos > max_r)
					max_r = row_pos;
				if ({1'b0, hi} > max_col)
					max_col = {1'b0, hi};
			end
			if ({1'b0, lo} < min_col)
				min_col = {1'b0, lo};
			last_pos = {row_pos, hi};
		end
		// row length 0 acts as 1, anything past 128 as 128
		if (row_words_q == '0)
			eff = 1;
		else if (row_words_q > bbx_pkg::ROW_WORDS_MAX)
			eff = int'(bbx_pkg::ROW_WORDS_MAX);
		else
			eff = int'(row_words_q);
		word_pos = word_pos + 1'b1;
		if (word_pos == '0 || int'(word_pos) >= eff) begin
			word_pos = '0;
			row_pos  = row_pos + 1'b1;
		end
		if (item.last_word)
			close_image();
	endtask

	task automatic check_result(bbx_pkg::out_item_t got);
		bbx_pkg::out_item_t want;
		if (expected_boxes.size() == 0) begin
			errors++;
			$display("%0t: result with no image outstanding, got %h", $time, got);
		end else begin
			want = expected_boxes.pop_front();
			checked++;
			for (int i = 0; i < 9; i++)
				if (field_of(want, i) != field_of(got, i)) begin
					errors++;
					$display("%0t: %s expected %0d got %0d", $time, field_names[i],
						field_of(want, i), field_of(got, i));
				end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_words_q = bbx_pkg::ROW_WORDS_RESET;
			width_q     = bbx_pkg::IMAGE_WIDTH_RESET;
			clear_image();
			expected_boxes.delete();
		end else begin
			if (out_valid && !out_stall)
				check_result(out_data);
			if (psel && penable && pwrite && pready)
				write_reg(paddr[2], pwdata);
			if (in_valid && !in_stall)
				fold_word(in_data);
		end
		pending         <= expected_boxes.size();
		fail_count      <= errors;
		results_checked <= checked;
	end

endmodule

### tb/tb_bitmap_bounding_box_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bitmap_bounding_box_top: regression for the bitmap bounding box
// drives raster word transfers and register writes under varying idle
// mixes; a separate checker predicts every image's box and compares
// ----------------------------------------------------------------------------
module tb_bitmap_bounding_box_top;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	bbx_pkg::in_item_t  in_data = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	bbx_pkg::out_item_t out_data;
	logic               psel = 1'b0;
	logic               penable = 1'b0;
	logic               pwrite = 1'b0;
	logic [2:0]         paddr = '0;
	logic [31:0]        pwdata = '0;
	logic [31:0]        prdata;
	logic               pready;

	int pending;
	int fail_count;
	int results_checked;

	// idle percentages of the two sides
	int send_idle_pct = 0;
	int recv_idle_pct = 0;

	int words_sent = 0;
	int images_sent = 0;

	// register settings per phase, a few slots randomised at start
	logic [bbx_pkg::RW_W-1:0] rw_list [12] = '{8'd1, 8'd128, 8'd3, 8'd0, 8'd255,
		8'd2, 8'd7, 8'd64, 8'd200, 8'd5, 8'd9, 8'd1};
	logic [bbx_pkg::IW_W-1:0] iw_list [12] = '{13'd32, 13'd4096, 13'd100, 13'd0,
		13'd8191, 13'd40, 13'd50, 13'd1, 13'd4096, 13'd32, 13'd60, 13'd4095};

	bitmap_bounding_box_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready)
	);

	bbx_checker u_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.in_data         (in_data),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.out_data        (out_data),
		.psel            (psel),
		.penable         (penable),
		.pwrite          (pwrite),
		.paddr           (paddr),
		.pwdata          (pwdata),
		.pready          (pready),
		.pending         (pending),
		.fail_count      (fail_count),
		.results_checked (results_checked)
	);

	// 12 ns period
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// receiver side: random stall at the current idle rate
	always @(posedge clk)
		out_stall <= ($urandom_range(99) < recv_idle_pct);

	// mostly sparse words, with single bits, edge bits and full words mixed in
	function automatic logic [31:0] random_pixels();
		case ($urandom_range(9))
			0, 1, 2, 3: return 32'h0000_0000;
			4: return 32'h1 << $urandom_range(31);
			5: return 32'hFFFF_FFFF;
			6: return 32'h8000_0001;
			default: return $urandom;
		endcase
	endfunction

	// one word transfer; random idle cycles ahead of it, then hold until taken
	task automatic send_word(input logic [31:0] pixels, input logic last);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= '{pixel_word: pixels, last_word: last};
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		words_sent++;
	endtask

	task automatic send_image(input int n_words, input logic empty);
		for (int k = 0; k < n_words; k++)
			send_word(empty ? 32'h0 : random_pixels(), k == n_words - 1);
		images_sent++;
	endtask

	// sender holds off until every box has come back, then lets the back end drain
	task automatic wait_idle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (4)
			@(posedge clk);
	endtask

	// setup then access cycle, then back to idle; upper data bits carry
	// junk the register drops
	task automatic apb_write(input logic sel, input logic [31:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {sel, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic run_phase(input logic [bbx_pkg::RW_W-1:0] rw,
			input logic [bbx_pkg::IW_W-1:0] iw, input int budget);
		int eff;
		int used;
		int n;
		wait_idle();
		apb_write(bbx_pkg::REG_ROW_WORDS, {24'($urandom), rw});
		apb_write(bbx_pkg::REG_IMAGE_WIDTH, {19'($urandom), iw});
		eff = (rw == '0) ? 1 :
			(rw > bbx_pkg::ROW_WORDS_MAX) ? int'(bbx_pkg::ROW_WORDS_MAX) : int'(rw);
		// first image always spans at least one full row so wide settings reach high columns
		n = eff + $urandom_range(eff);
		send_image(n, 1'b0);
		used = n;
		while (used < budget) begin
			if ($urandom_range(7) == 0)
				n = $urandom_range(2 * eff + 2, 1);
			else
				n = $urandom_range(24, 1);
			send_image(n, $urandom_range(7) == 0);
			used += n;
		end
	endtask

	initial begin
		rw_list[6]  = bbx_pkg::RW_W'($urandom_range(128, 1));
		rw_list[10] = bbx_pkg::RW_W'($urandom_range(255));
		iw_list[5]  = bbx_pkg::IW_W'($urandom_range(4096, 1));
		iw_list[6]  = bbx_pkg::IW_W'($urandom_range(4096, 1));
		iw_list[10] = bbx_pkg::IW_W'($urandom_range(8191));

		repeat (11)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle_pct = 7;
		recv_idle_pct = 51;

		// directed, reset settings: one word per row, width 32
		// empty image
		send_word(32'h0000_0000, 1'b1);
		// single full word
		send_word(32'hFFFF_FFFF, 1'b1);
		// lowest then highest bit on successive rows
		send_word(32'h0000_0001, 1'b0);
		send_word(32'h8000_0000, 1'b1);
		// gaps between set rows, interior columns
		send_word(32'h0000_0000, 1'b0);
		send_word(32'h0001_0000, 1'b0);
		send_word(32'h0000_0000, 1'b0);
		send_word(32'h0000_0100, 1'b1);
		// alternating patterns, every bit both ways
		send_word(32'hA5A5_A5A5, 1'b0);
		send_word(32'h5A5A_5A5A, 1'b1);
		// empty word carrying the last flag after set pixels
		send_word(32'h8000_0000, 1'b0);
		send_word(32'h0000_0001, 1'b0);
		send_word(32'h0000_0000, 1'b1);
		images_sent += 6;

		// random phases over three idle mixes, four register settings each
		for (int m = 0; m < 3; m++) begin
			case (m)
				0: begin
					send_idle_pct = 7;
					recv_idle_pct = 51;
				end
				1: begin
					send_idle_pct = 51;
					recv_idle_pct = 7;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			for (int p = 0; p < 4; p++)
				run_phase(rw_list[m * 4 + p], iw_list[m * 4 + p], 90);
		end

		wait_idle();
		repeat (8)
			@(posedge clk);

		$display("%0d boxes checked from %0d images, %0d word transfers",
			results_checked, images_sent, words_sent);
		$display("row lengths 0 to 255, widths 0 to 8191, empty images, 3 idle mixes");
		if (fail_count == 0)
			$display("bitmap_bounding_box_top regression: pass");
		else
			$display("bitmap_bounding_box_top regression: fail");
		$finish;
	end

	// overall time limit, well past the slowest correct run
	initial begin
		#6_000_000;
		$display("bitmap_bounding_box_top regression: fail");
		$finish;
	end

endmodule
